// ----- hw/rtl/bitonic_sort_32_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the bitonic sorter
// Each macro expects clk and rst_n in scope at the point of use.
// ----------------------------------------------------------------------------
`ifndef BITONIC_SORT_32_DEFINES_SVH
`define BITONIC_SORT_32_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BS32_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bitonic_sort_32: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define BS32_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bitonic_sort_32: next-cycle check failed");

`endif

// ----- hw/rtl/bs32_pkg.sv -----
// ----------------------------------------------------------------------------
// bs32_pkg
// Sizes, types and index helpers shared by bs32_cex and bitonic_sort_32.
// ----------------------------------------------------------------------------
`default_nettype none

package bs32_pkg;

  localparam int COUNT      = 32;
  localparam int DATA_WIDTH = 16;
  localparam int IDX_W      = $clog2(COUNT);
  localparam int BANK_DEPTH = COUNT / 2;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int KW         = $clog2(IDX_W + 1);

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic [IDX_W-1:0]             idx_t;
  typedef logic [BANK_AW-1:0]           baddr_t;
  typedef logic [KW-1:0]                lvl_t;

  // One compare-exchange issued to the datapath.
  typedef struct packed {
    logic vld;
    idx_t lo_idx;
    idx_t hi_idx;
    logic up;
  } cex_op_t;

  // One write into a bank.
  typedef struct packed {
    logic   we;
    baddr_t addr;
    data_t  data;
  } bank_wr_t;

  // Entries are spread over two banks by index parity. The partners of a
  // compare-exchange differ in exactly one bit, so they never share a bank.
  function automatic logic bank_of(idx_t idx);
    return ^idx;
  endfunction

  function automatic baddr_t bank_addr(idx_t idx);
    idx_t sh;
    sh = idx >> 1;
    return sh[BANK_AW-1:0];
  endfunction

  // Lower index of pair p at distance 2**j: a zero bit is inserted at bit j.
  function automatic idx_t pair_lo(baddr_t p, lvl_t j);
    idx_t pe;
    idx_t m;
    pe = IDX_W'(p);
    m  = (IDX_W'(1) << j) - IDX_W'(1);
    return ((pe & ~m) << 1) | (pe & m);
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/bs32_ram.sv -----
// ----------------------------------------------------------------------------
// bs32_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bs32_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bs32_cex.sv -----
// ----------------------------------------------------------------------------
// bs32_cex
// Compare-exchange stage: holds an issued pair while its read returns, then
// orders the two entries and writes them back to their banks.
// ----------------------------------------------------------------------------
`default_nettype none

module bs32_cex
  import bs32_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire cex_op_t op_i,
  input  wire data_t   bank0_rd,
  input  wire data_t   bank1_rd,
  output bank_wr_t     bank0_wr,
  output bank_wr_t     bank1_wr
);

  logic    op_vld_r;
  cex_op_t op_r;
  logic    lo_bank;
  data_t   a_val;
  data_t   b_val;
  logic    swap;
  data_t   new_lo;
  data_t   new_hi;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_vld_r <= 1'b0;
    end else begin
      op_vld_r <= op_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_i;
  end

  always_comb begin
    lo_bank = bank_of(op_r.lo_idx);
    a_val   = lo_bank ? bank1_rd : bank0_rd;
    b_val   = lo_bank ? bank0_rd : bank1_rd;
    // A strict misorder swaps; in descending order equal values swap too.
    swap    = ((a_val > b_val) == op_r.up);
    new_lo  = swap ? b_val : a_val;
    new_hi  = swap ? a_val : b_val;

    bank0_wr.we   = op_vld_r;
    bank1_wr.we   = op_vld_r;
    bank0_wr.addr = lo_bank ? bank_addr(op_r.hi_idx) : bank_addr(op_r.lo_idx);
    bank1_wr.addr = lo_bank ? bank_addr(op_r.lo_idx) : bank_addr(op_r.hi_idx);
    bank0_wr.data = lo_bank ? new_hi : new_lo;
    bank1_wr.data = lo_bank ? new_lo : new_hi;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bitonic_sort_32.sv -----
// ----------------------------------------------------------------------------
// bitonic_sort_32
// Collects a block of signed values, sorts it by a bitonic network held in
// two RAM banks, and streams the sorted block out.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a value is taken at a rising edge with start high and busy low.
//   Values of a block go in at one per cycle; busy stays low while loading.
//   The transaction that delivers the COUNT-th value starts the sort and
//   raises busy until the sorted block has been sent.
//   Sort: log2(COUNT)*(log2(COUNT)+1)/2 stages, each issuing COUNT/2
//   compare-exchanges, one per cycle, then a wait state while the last
//   write lands. The rate is set by the one read and one write port of
//   each bank.
//   Output: COUNT results on out_valid, one per cycle; out_last marks
//   the final one.
//   The receiver cannot stall; each result stands for one cycle only.
//   Config: cfg_data sets the order (1 ascending, 0 descending) on a
//   cfg_valid transaction; cfg_ready is always high.
//   Reset empties the block and selects ascending order; stored values are
//   not cleared, as every entry is loaded before the sort reads it.
// ----------------------------------------------------------------------------
`default_nettype none

module bitonic_sort_32
  import bs32_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  start,
  output logic       busy,
  input  wire data_t in_value,
  output logic       out_valid,
  output data_t      out_sorted_value,
  output logic       out_last,
  input  wire logic  cfg_valid,
  output logic       cfg_ready,
  input  wire logic  cfg_data
);

  `include "bitonic_sort_32_defines.svh"

  typedef enum logic [3:0] {
    S_LOAD = 4'b0001,
    S_SORT = 4'b0010,
    S_WAIT = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  localparam idx_t   LAST_IDX  = IDX_W'(COUNT - 1);
  localparam baddr_t LAST_PAIR = BANK_AW'(COUNT / 2 - 1);
  localparam lvl_t   TOP_LVL   = KW'(IDX_W);

  state_t state_r, state_nxt;
  idx_t   idx_r, idx_nxt;
  baddr_t pair_r, pair_nxt;
  lvl_t   k_r, k_nxt;
  lvl_t   j_r, j_nxt;
  logic   done_r, done_nxt;
  logic   asc_r;
  logic   emit_vld_r, emit_last_r, emit_bank_r;

  logic     in_accept;
  idx_t     lo_idx, hi_idx, lo_sh, rd_lo;
  cex_op_t  op;
  data_t    bank0_rd, bank1_rd;
  bank_wr_t cex_wr0, cex_wr1;
  bank_wr_t wr0, wr1;
  baddr_t   rd_addr0, rd_addr1;

  assign busy      = (state_r != S_LOAD);
  assign in_accept = start & ~busy;
  assign cfg_ready = 1'b1;

  // Issue side of the network.
  always_comb begin
    lo_idx = pair_lo(pair_r, j_r);
    hi_idx = lo_idx | (IDX_W'(1) << j_r);
    lo_sh  = lo_idx >> k_r;
    op.vld    = (state_r == S_SORT);
    op.lo_idx = lo_idx;
    op.hi_idx = hi_idx;
    // Sub-blocks of size 2**k with an even block number sort ascending,
    // odd ones descending; the final merge follows the configured order.
    op.up     = (k_r == TOP_LVL) ? asc_r : ~lo_sh[0];
  end

  always_comb begin
    rd_lo = (state_r == S_EMIT) ? idx_r : lo_idx;
    rd_addr0 = bank_of(rd_lo) ? bank_addr(hi_idx) : bank_addr(rd_lo);
    rd_addr1 = bank_of(rd_lo) ? bank_addr(rd_lo) : bank_addr(hi_idx);
  end

  always_comb begin
    wr0 = cex_wr0;
    wr1 = cex_wr1;
    if (in_accept) begin
      wr0.we   = ~bank_of(idx_r);
      wr0.addr = bank_addr(idx_r);
      wr0.data = in_value;
      wr1.we   = bank_of(idx_r);
      wr1.addr = bank_addr(idx_r);
      wr1.data = in_value;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    pair_nxt  = pair_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    done_nxt  = done_r;
    case (state_r)
      S_LOAD: begin
        if (in_accept) begin
          idx_nxt = idx_r + IDX_W'(1);
          if (idx_r == LAST_IDX) begin
            idx_nxt   = '0;
            state_nxt = S_SORT;
            pair_nxt  = '0;
            k_nxt     = KW'(1);
            j_nxt     = '0;
            done_nxt  = 1'b0;
          end
        end
      end
      S_SORT: begin
        pair_nxt = pair_r + BANK_AW'(1);
        if (pair_r == LAST_PAIR) begin
          pair_nxt  = '0;
          state_nxt = S_WAIT;
          if (j_r == '0) begin
            if (k_r == TOP_LVL) begin
              done_nxt = 1'b1;
            end else begin
              k_nxt = k_r + KW'(1);
              j_nxt = k_r;
            end
          end else begin
            j_nxt = j_r - KW'(1);
          end
        end
      end
      S_WAIT: begin
        // The last write of a stage lands here before the next read.
        state_nxt = done_r ? S_EMIT : S_SORT;
      end
      S_EMIT: begin
        idx_nxt = idx_r + IDX_W'(1);
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
        idx_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      idx_r       <= '0;
      pair_r      <= '0;
      k_r         <= KW'(1);
      j_r         <= '0;
      done_r      <= 1'b0;
      asc_r       <= 1'b1;
      emit_vld_r  <= 1'b0;
      emit_last_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      pair_r      <= pair_nxt;
      k_r         <= k_nxt;
      j_r         <= j_nxt;
      done_r      <= done_nxt;
      emit_vld_r  <= (state_r == S_EMIT);
      emit_last_r <= (state_r == S_EMIT) && (idx_r == LAST_IDX);
      if (cfg_valid && cfg_ready) begin
        asc_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    emit_bank_r <= bank_of(idx_r);
  end

  assign out_valid        = emit_vld_r;
  assign out_last         = emit_vld_r & emit_last_r;
  assign out_sorted_value = emit_bank_r ? bank1_rd : bank0_rd;

  bs32_ram #(
    .DEPTH (BANK_DEPTH),
    .WIDTH (DATA_WIDTH),
    .AW    (BANK_AW)
  ) u_bank0 (
    .clk     (clk),
    .we      (wr0.we),
    .wr_addr (wr0.addr),
    .wr_data (wr0.data),
    .rd_addr (rd_addr0),
    .rd_data (bank0_rd)
  );

  bs32_ram #(
    .DEPTH (BANK_DEPTH),
    .WIDTH (DATA_WIDTH),
    .AW    (BANK_AW)
  ) u_bank1 (
    .clk     (clk),
    .we      (wr1.we),
    .wr_addr (wr1.addr),
    .wr_data (wr1.data),
    .rd_addr (rd_addr1),
    .rd_data (bank1_rd)
  );

  bs32_cex u_cex (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_i     (op),
    .bank0_rd (bank0_rd),
    .bank1_rd (bank1_rd),
    .bank0_wr (cex_wr0),
    .bank1_wr (cex_wr1)
  );

  `BS32_ASSERT_NOW(a_cex_wr_in_sort, (cex_wr0.we || cex_wr1.we),
                   (state_r == S_SORT || state_r == S_WAIT))
  `BS32_ASSERT_NOW(a_busy_mid_run, (out_valid && !out_last), busy)
  `BS32_ASSERT_NEXT(a_last_ends_run, out_last, !out_valid)
  `BS32_ASSERT_NEXT(a_full_starts_sort, (in_accept && idx_r == LAST_IDX),
                    (state_r == S_SORT))
  `BS32_ASSERT_NEXT(a_wait_exit, (state_r == S_WAIT),
                    (state_r == S_SORT || state_r == S_EMIT))

endmodule

`default_nettype wire
